>>> hdl/bve_pkg.sv
// ============================================================================
// bve_pkg
// Shared types and constants for the multiword bit vector engine
// ============================================================================
package bve_pkg;

    localparam int WORD_BITS   = 64;
    localparam int BIT_COUNT_W = 11;
    localparam int INDEX_W     = 10;
    localparam int BPOS_W      = 6;                  // bit position inside a word
    localparam int WIDX_W      = INDEX_W - BPOS_W;   // word holding an addressed bit
    localparam int NWORDS_W    = 6;                  // used word count, up to 32
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RESET = 11'd1024;
    localparam logic [WORD_BITS-1:0]   GOLDEN          = 64'h0000_0000_9e37_79b9;

    // operation codes as seen on the input channel
    typedef enum logic [2:0] {
        OP_GET   = 3'd0,
        OP_SET   = 3'd1,
        OP_FLIP  = 3'd2,
        OP_INC   = 3'd3,
        OP_HASH  = 3'd4,
        OP_CLEAR = 3'd5
    } op_t;

    // classified command kinds handed to the back end
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_GET,
        CMD_SET,
        CMD_FLIP,
        CMD_INC,
        CMD_HASH,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [WIDX_W-1:0]     widx;
        logic [BPOS_W-1:0]     bpos;
        logic                  value;
        logic                  err;
        logic [NWORDS_W-1:0]   nwords;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_BIT,
        ST_INC,
        ST_HASH,
        ST_DONE
    } state_t;

endpackage

>>> hdl/bve_front.sv
// ============================================================================
// bve_front
// Input acceptance, size register and classification of each transaction
// ============================================================================
module bve_front #(
    parameter int MAX_WORDS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bve_pkg::BIT_COUNT_W-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          operation,
    input  logic [bve_pkg::INDEX_W-1:0]         bit_addr,
    input  logic                                bit_value,
    input  logic                                q_full,
    input  logic                                init_busy,
    output logic                                q_push,
    output bve_pkg::cmd_t                       q_cmd
);

    localparam int CAP = MAX_WORDS * bve_pkg::WORD_BITS;

    logic [bve_pkg::BIT_COUNT_W-1:0] bit_count_reg;
    logic [bve_pkg::BIT_COUNT_W-1:0] bit_count_next;
    logic [bve_pkg::BIT_COUNT_W-1:0] used_bits;
    logic [bve_pkg::BIT_COUNT_W:0]   round_sum;
    logic                            beyond_size;

    assign bit_count_next = cfg_wr_en ? cfg_wr_data : bit_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= bve_pkg::BIT_COUNT_RESET;
        end
        else
        begin
            bit_count_reg <= bit_count_next;
        end
    end

    // size limited to the storage, word count rounded up
    assign used_bits    = (32'(bit_count_reg) > CAP) ? bve_pkg::BIT_COUNT_W'(CAP)
                                                     : bit_count_reg;
    assign round_sum    = {1'b0, used_bits} + (bve_pkg::BIT_COUNT_W + 1)'(bve_pkg::WORD_BITS - 1);
    assign beyond_size  = {1'b0, bit_addr} >= used_bits;

    always_comb
    begin
        q_cmd.kind   = bve_pkg::CMD_NONE;
        q_cmd.widx   = bit_addr[bve_pkg::INDEX_W-1:bve_pkg::BPOS_W];
        q_cmd.bpos   = bit_addr[bve_pkg::BPOS_W-1:0];
        q_cmd.value  = bit_value;
        q_cmd.err    = 1'b0;
        q_cmd.nwords = round_sum[bve_pkg::BIT_COUNT_W:bve_pkg::BPOS_W];
        case (operation)
            bve_pkg::OP_GET:   q_cmd.kind = bve_pkg::CMD_GET;
            bve_pkg::OP_SET:   q_cmd.kind = bve_pkg::CMD_SET;
            bve_pkg::OP_FLIP:  q_cmd.kind = bve_pkg::CMD_FLIP;
            bve_pkg::OP_INC:   q_cmd.kind = bve_pkg::CMD_INC;
            bve_pkg::OP_HASH:  q_cmd.kind = bve_pkg::CMD_HASH;
            bve_pkg::OP_CLEAR: q_cmd.kind = bve_pkg::CMD_CLEAR;
            default:           q_cmd.kind = bve_pkg::CMD_NONE;
        endcase
        // bit access past the size: flag only, vector untouched
        if ((operation inside {bve_pkg::OP_GET, bve_pkg::OP_SET, bve_pkg::OP_FLIP})
            && beyond_size)
        begin
            q_cmd.kind = bve_pkg::CMD_NONE;
            q_cmd.err  = 1'b1;
        end
    end

    assign in_ready = !q_full && !init_busy;
    assign q_push   = in_valid && in_ready;

endmodule

>>> hdl/bve_queue.sv
// ============================================================================
// bve_queue
// Two-entry command queue between front and back
// ============================================================================
module bve_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bve_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output bve_pkg::cmd_t   head
);

    bve_pkg::cmd_t                  slots_reg [bve_pkg::QUEUE_DEPTH];
    logic [bve_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [bve_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [bve_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [bve_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [bve_pkg::QCNT_W-1:0]     count_reg;
    logic [bve_pkg::QCNT_W-1:0]     count_next;

    assign full  = count_reg == bve_pkg::QCNT_W'(bve_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/bve_back.sv
// ============================================================================
// bve_back
// Word store, command sequencer and output register
// ============================================================================
module bve_back #(
    parameter int MAX_WORDS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  bve_pkg::cmd_t                   q_head,
    output logic                            q_pop,
    output logic                            init_busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            bit_out,
    output logic [bve_pkg::WORD_BITS-1:0]   hash_out,
    output logic                            range_error
);

    localparam int WA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WC = $clog2(MAX_WORDS + 1);
    localparam int WB = bve_pkg::WORD_BITS;

    logic [WB-1:0]          mem [MAX_WORDS];
    logic [WB-1:0]          rd_data_reg;
    logic                   rd_en;
    logic [WA-1:0]          rd_addr;
    logic                   wr_en;
    logic [WA-1:0]          wr_addr;
    logic [WB-1:0]          wr_data;

    bve_pkg::state_t        state_reg;
    bve_pkg::state_t        state_next;
    logic [WC-1:0]          cnt_reg;
    logic [WC-1:0]          cnt_next;
    bve_pkg::cmd_t          cmd_reg;
    bve_pkg::cmd_t          cmd_next;
    logic [WB-1:0]          seed_reg;
    logic [WB-1:0]          seed_next;
    logic                   bit_res_reg;
    logic                   bit_res_next;
    logic                   init_reg;
    logic                   init_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   bit_out_reg;
    logic [WB-1:0]          hash_out_reg;
    logic                   range_error_reg;

    logic                   out_load;
    logic                   slot_free;
    logic                   last_sweep;
    logic                   walk_last;
    logic [WB-1:0]          inc_sum;
    logic [WB-1:0]          hash_mix;
    logic [WB-1:0]          bit_mask;
    logic [WA-1:0]          next_addr;
    logic                   head_is_bit;

    assign slot_free   = !out_valid_reg || out_ready;
    assign last_sweep  = int'(cnt_reg) == MAX_WORDS - 1;
    assign walk_last   = (int'(cnt_reg) + 1) == int'(cmd_reg.nwords);
    assign inc_sum     = rd_data_reg + WB'(1);
    assign hash_mix    = seed_reg ^ (rd_data_reg + bve_pkg::GOLDEN
                                     + (seed_reg << 6) + (seed_reg >> 2));
    assign bit_mask    = WB'(1) << cmd_reg.bpos;
    assign next_addr   = WA'(cnt_reg + 1'b1);
    assign head_is_bit = (q_head.kind == bve_pkg::CMD_GET) || (q_head.kind == bve_pkg::CMD_SET)
                         || (q_head.kind == bve_pkg::CMD_FLIP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bve_pkg::ST_SWEEP:
            begin
                if (last_sweep)
                begin
                    state_next = init_reg ? bve_pkg::ST_IDLE : bve_pkg::ST_DONE;
                end
            end
            bve_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.kind)
                        bve_pkg::CMD_GET,
                        bve_pkg::CMD_SET,
                        bve_pkg::CMD_FLIP:  state_next = bve_pkg::ST_BIT;
                        bve_pkg::CMD_INC:   state_next = (q_head.nwords == '0) ? bve_pkg::ST_DONE
                                                                              : bve_pkg::ST_INC;
                        bve_pkg::CMD_HASH:  state_next = (q_head.nwords == '0) ? bve_pkg::ST_DONE
                                                                              : bve_pkg::ST_HASH;
                        bve_pkg::CMD_CLEAR: state_next = bve_pkg::ST_SWEEP;
                        default:            state_next = bve_pkg::ST_DONE;
                    endcase
                end
            end
            bve_pkg::ST_BIT:
            begin
                state_next = bve_pkg::ST_DONE;
            end
            bve_pkg::ST_INC:
            begin
                if ((inc_sum != '0) || walk_last)
                begin
                    state_next = bve_pkg::ST_DONE;
                end
            end
            bve_pkg::ST_HASH:
            begin
                if (walk_last)
                begin
                    state_next = bve_pkg::ST_DONE;
                end
            end
            bve_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = bve_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bve_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        seed_next    = seed_reg;
        bit_res_next = bit_res_reg;
        init_next    = init_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = cnt_reg[WA-1:0];
        wr_data      = '0;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            bve_pkg::ST_SWEEP:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_sweep)
                begin
                    init_next = 1'b0;
                end
            end
            bve_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_head;
                    cnt_next     = '0;
                    bit_res_next = 1'b0;
                    seed_next    = WB'(q_head.nwords);
                    rd_en        = 1'b1;
                    rd_addr      = head_is_bit ? WA'(q_head.widx) : '0;
                end
            end
            bve_pkg::ST_BIT:
            begin
                wr_addr = WA'(cmd_reg.widx);
                case (cmd_reg.kind)
                    bve_pkg::CMD_GET:
                    begin
                        bit_res_next = rd_data_reg[cmd_reg.bpos];
                    end
                    bve_pkg::CMD_SET:
                    begin
                        wr_en   = 1'b1;
                        wr_data = cmd_reg.value ? (rd_data_reg | bit_mask)
                                                : (rd_data_reg & ~bit_mask);
                    end
                    bve_pkg::CMD_FLIP:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg ^ bit_mask;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            bve_pkg::ST_INC:
            begin
                wr_en   = 1'b1;
                wr_data = inc_sum;
                // carry ripples on only while a word wraps to zero
                if ((inc_sum == '0) && !walk_last)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = next_addr;
                end
            end
            bve_pkg::ST_HASH:
            begin
                seed_next = hash_mix;
                if (!walk_last)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = next_addr;
                end
            end
            bve_pkg::ST_DONE:
            begin
                out_load = slot_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bve_pkg::ST_SWEEP;
            cnt_reg       <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        seed_reg    <= seed_next;
        bit_res_reg <= bit_res_next;
        if (out_load)
        begin
            bit_out_reg     <= bit_res_reg;
            hash_out_reg    <= (cmd_reg.kind == bve_pkg::CMD_HASH) ? seed_reg : '0;
            range_error_reg <= cmd_reg.err;
        end
    end

    // word store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign init_busy   = init_reg;
    assign out_valid   = out_valid_reg;
    assign bit_out     = bit_out_reg;
    assign hash_out    = hash_out_reg;
    assign range_error = range_error_reg;

endmodule

>>> hdl/multiword_bit_vector_engine.sv
// ============================================================================
// multiword_bit_vector_engine
// Bit vector of up to MAX_WORDS 64-bit words with bit access, increment,
// hash and clear
// ============================================================================
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ------------------------------
//  in        sink       in_valid / in_ready       operation, bit_addr, bit_value
//  out       source     out_valid / out_ready     bit_out, hash_out, range_error
//  cfg       sink       cfg_wr_en (no wait)       cfg_wr_data (bit_count)
//
//  one transaction at a time in the back end; on an idle block the back end
//  pops the command, accesses the word and then raises out_valid with the
//  result for get, set and flip; flagged or unknown operations skip the word access
//  increment visits words until the carry stops (at most n, the used word
//  count) and hash visits all n words; the word store gives one word a cycle
//  on its single read port
//  clear zeroes every word of the store, one word written per cycle
//  after reset a clearing pass zeroes the store, with in_ready held low;
//  configuration writes are taken throughout
//  the two-entry queue keeps the input side accepting up to two commands
//  while the back end works or while a finished result waits on out_ready
//
module multiword_bit_vector_engine #(
    parameter int MAX_WORDS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [bve_pkg::BIT_COUNT_W-1:0]     cfg_wr_data,
    // input transactions
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          operation,
    input  logic [bve_pkg::INDEX_W-1:0]         bit_addr,
    input  logic                                bit_value,
    // result transactions
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                bit_out,
    output logic [bve_pkg::WORD_BITS-1:0]       hash_out,
    output logic                                range_error
);

    // classified command path: front -> queue -> back
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic           init_busy;
    bve_pkg::cmd_t  q_cmd;
    bve_pkg::cmd_t  q_head;

    // front: holds bit_count, works out the word count and range flag
    bve_front #(
        .MAX_WORDS  (MAX_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .bit_addr   (bit_addr),
        .bit_value  (bit_value),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // short queue so front and back stall independently
    bve_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    // back: word store, sequencer for the word walks, output register
    bve_back #(
        .MAX_WORDS  (MAX_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .init_busy  (init_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bit_out    (bit_out),
        .hash_out   (hash_out),
        .range_error(range_error)
    );

endmodule

>>> hdl/bve_checker.sv
// ============================================================================
// bve_checker
// Port-level checks on the result channel, bound to the top level
// ============================================================================
module bve_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 bit_out,
    input logic [bve_pkg::WORD_BITS-1:0]        hash_out,
    input logic                                 range_error
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before acceptance");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(bit_out) && $stable(hash_out)
                                    && $stable(range_error))
        else $error("result payload changed while stalled");

    // a flagged index reads nothing and hashes nothing
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> !bit_out && (hash_out == '0))
        else $error("range error with non-zero result fields");

    // a bit read never carries a hash value or a range error
    a_bit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_out |-> (hash_out == '0) && !range_error)
        else $error("bit result mixed with hash or error");

endmodule

bind multiword_bit_vector_engine bve_checker u_bve_checker (.*);
